// ----- design/ticket_reader_writer_lock_macros.svh -----
// Assertion macros for the ticket reader/writer lock
`ifndef TICKET_READER_WRITER_LOCK_MACROS_SVH
`define TICKET_READER_WRITER_LOCK_MACROS_SVH

// check that a condition implies another in the same cycle
`define TRWL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// check that a condition implies another in the next cycle
`define TRWL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/trwl_pkg.sv -----
// Shared types and defaults for the ticket reader/writer lock
package trwl_pkg;

    localparam int DEF_NUM_REQUESTERS = 16;
    localparam int DEF_TICKET_BITS    = 16;
    localparam int DEF_TICKET_WINDOW  = 16;

    typedef enum logic [2:0] {
        CMD_ACQUIRE = 3'd0,
        CMD_WAIT    = 3'd1,
        CMD_CANCEL  = 3'd2,
        CMD_TRY     = 3'd3,
        CMD_RELEASE = 3'd4,
        CMD_CLOSE   = 3'd5,
        CMD_RSVD6   = 3'd6,
        CMD_RSVD7   = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_QUEUED     = 3'd1,
        ST_DEADLOCK   = 3'd2,
        ST_BUSY       = 3'd3,
        ST_INVALID    = 3'd4,
        ST_NOT_READY  = 3'd5,
        ST_QUEUE_FULL = 3'd6,
        ST_UNKNOWN    = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_ADV  = 3'b100
    } t_state;

endpackage

// ----- design/ticket_reader_writer_lock.sv -----
// Ticket reader/writer lock: holder flags in a per-requester memory, tickets in registers
// o_done is registered in the execute state, or, when service advances, in the advance state,
// which first moves on past cancelled tickets (one skipped ticket per cycle).
// Throughput: one request at a time; busy is high from acceptance until o_done.
// Holder flags are read at acceptance from a one-port synchronous memory.
// Reset (synchronous, active low) clears tickets, counts, skip marks and entry valid bits.
`include "ticket_reader_writer_lock_macros.svh"

module ticket_reader_writer_lock #(
    parameter int NUM_REQUESTERS = trwl_pkg::DEF_NUM_REQUESTERS,
    parameter int TICKET_BITS    = trwl_pkg::DEF_TICKET_BITS,
    parameter int TICKET_WINDOW  = trwl_pkg::DEF_TICKET_WINDOW
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_cmd,
    input  logic [3:0]  i_requester,
    input  logic        i_write_mode,
    input  logic [15:0] i_ticket,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [15:0] o_issued_ticket,
    output logic        o_all_free
);

    localparam int IDX_W = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;
    localparam int AW    = (IDX_W > 4) ? IDX_W : 4;
    localparam int CW    = $clog2(NUM_REQUESTERS + 1);
    localparam int SW    = (TICKET_WINDOW > 1) ? $clog2(TICKET_WINDOW) : 1;
    localparam int OW    = (TICKET_BITS > SW) ? TICKET_BITS : SW;
    localparam logic [TICKET_BITS-1:0] TK_MAX = {TICKET_BITS{1'b1}};

    trwl_pkg::t_state  r_state;
    trwl_pkg::t_cmd    r_cmd;
    logic [3:0]        r_req;
    logic              r_wr;
    logic [TICKET_BITS-1:0]   r_tk;
    logic [TICKET_BITS-1:0]   r_next;
    logic [TICKET_BITS-1:0]   r_serv;
    logic [TICKET_WINDOW-1:0] r_skip;
    logic [CW-1:0]     r_rcnt;
    logic [CW-1:0]     r_wcnt;
    logic [1:0]        r_mem [NUM_REQUESTERS];
    logic [NUM_REQUESTERS-1:0] r_val;
    logic [1:0]        r_rdata;
    logic              r_rvalid;
    trwl_pkg::t_status r_status;
    logic [15:0]       r_issued;

    logic              accept;
    logic              in_ok;
    logic [AW-1:0]     in_ext;
    logic [IDX_W-1:0]  rd_addr;
    logic [AW-1:0]     req_ext;
    logic [IDX_W-1:0]  wr_addr;
    logic              req_ok;
    logic [1:0]        flags;
    logic [1:0]        n_flags;
    logic              holds;
    logic [TICKET_BITS-1:0] pend;
    logic [TICKET_BITS-1:0] offset;
    logic [OW-1:0]     off_ext;
    logic [SW-1:0]     off_idx;
    logic              outst;
    logic              skip_hit;
    logic              win_full;
    trwl_pkg::t_status n_status;
    logic [15:0]       n_issued;
    logic [TICKET_BITS-1:0] n_next;
    logic              do_adv;
    logic              do_mark;
    logic              do_write;
    logic [CW-1:0]     n_rcnt;
    logic [CW-1:0]     n_wcnt;

    assign accept  = start && !busy;
    assign busy    = (r_state != trwl_pkg::S_IDLE);
    assign in_ext  = AW'(i_requester);
    assign rd_addr = in_ext[IDX_W-1:0];
    assign in_ok   = (32'(i_requester) < 32'(NUM_REQUESTERS));
    assign req_ext = AW'(r_req);
    assign wr_addr = req_ext[IDX_W-1:0];
    assign req_ok  = (32'(r_req) < 32'(NUM_REQUESTERS));

    assign flags    = (req_ok && r_rvalid) ? r_rdata : 2'b00;
    assign holds    = |flags;
    assign pend     = r_next - r_serv;
    assign offset   = r_tk - r_serv;
    assign off_ext  = OW'(offset);
    assign off_idx  = off_ext[SW-1:0];
    assign outst    = (offset < pend);
    assign skip_hit = outst && r_skip[off_idx];
    assign win_full = (32'(pend) >= 32'(TICKET_WINDOW)) || (pend == TK_MAX);

    always_comb begin
        n_status = trwl_pkg::ST_OK;
        n_issued = 16'd0;
        n_next   = r_next;
        n_flags  = flags;
        do_adv   = 1'b0;
        do_mark  = 1'b0;
        if (r_cmd == trwl_pkg::CMD_RSVD6 || r_cmd == trwl_pkg::CMD_RSVD7) begin
            n_status = trwl_pkg::ST_UNKNOWN;
        end else if (!req_ok && r_cmd != trwl_pkg::CMD_CANCEL) begin
            n_status = trwl_pkg::ST_INVALID;
        end else begin
            case (r_cmd)
                trwl_pkg::CMD_ACQUIRE: begin
                    if (holds) begin
                        n_status = trwl_pkg::ST_DEADLOCK;
                    end else if (win_full) begin
                        n_status = trwl_pkg::ST_QUEUE_FULL;
                    end else begin
                        n_issued = 16'(r_next);
                        n_next   = r_next + 1'b1;
                        n_status = trwl_pkg::ST_QUEUED;
                    end
                end
                trwl_pkg::CMD_WAIT: begin
                    if (!outst || skip_hit) begin
                        n_status = trwl_pkg::ST_INVALID;
                    end else if (offset != '0 || r_wcnt != '0 || (r_wr && r_rcnt != '0)) begin
                        n_status = trwl_pkg::ST_NOT_READY;
                    end else begin
                        n_flags = r_wr ? (flags | 2'b10) : (flags | 2'b01);
                        do_adv  = 1'b1;
                    end
                end
                trwl_pkg::CMD_CANCEL: begin
                    if (!outst) begin
                        n_status = trwl_pkg::ST_INVALID;
                    end else if (offset == '0) begin
                        do_adv = 1'b1;
                    end else begin
                        do_mark = 1'b1;
                    end
                end
                trwl_pkg::CMD_TRY: begin
                    if (holds || pend != '0 || r_wcnt != '0 || (r_wr && r_rcnt != '0)) begin
                        n_status = trwl_pkg::ST_BUSY;
                    end else begin
                        n_next  = r_next + 1'b1;
                        n_flags = r_wr ? (flags | 2'b10) : (flags | 2'b01);
                        do_adv  = 1'b1;
                    end
                end
                trwl_pkg::CMD_RELEASE: begin
                    if (!holds) begin
                        n_status = trwl_pkg::ST_INVALID;
                    end else begin
                        n_flags = 2'b00;
                    end
                end
                trwl_pkg::CMD_CLOSE: begin
                    if (!holds) begin
                        n_status = trwl_pkg::ST_INVALID;
                    end else begin
                        n_flags = r_wr ? (flags & 2'b01) : (flags & 2'b10);
                    end
                end
                default: begin
                    n_status = trwl_pkg::ST_UNKNOWN;
                end
            endcase
        end
    end

    assign do_write = req_ok && (n_flags != flags);
    assign n_rcnt   = r_rcnt + CW'(n_flags[0]) - CW'(flags[0]);
    assign n_wcnt   = r_wcnt + CW'(n_flags[1]) - CW'(flags[1]);

    // holder flag memory: read at acceptance, written back in the execute cycle
    always_ff @(posedge i_clk) begin
        if (accept && in_ok) begin
            r_rdata <= r_mem[rd_addr];
        end
        if (r_state == trwl_pkg::S_EXEC && do_write) begin
            r_mem[wr_addr] <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= trwl_pkg::S_IDLE;
            r_next   <= '0;
            r_serv   <= '0;
            r_skip   <= '0;
            r_rcnt   <= '0;
            r_wcnt   <= '0;
            r_val    <= '0;
            r_rvalid <= 1'b0;
            o_done   <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                trwl_pkg::S_IDLE: begin
                    if (accept) begin
                        r_cmd    <= trwl_pkg::t_cmd'(i_cmd);
                        r_req    <= i_requester;
                        r_wr     <= i_write_mode;
                        r_tk     <= TICKET_BITS'(i_ticket);
                        r_rvalid <= in_ok && r_val[rd_addr];
                        r_state  <= trwl_pkg::S_EXEC;
                    end
                end
                trwl_pkg::S_EXEC: begin
                    r_next   <= n_next;
                    r_rcnt   <= n_rcnt;
                    r_wcnt   <= n_wcnt;
                    r_status <= n_status;
                    r_issued <= n_issued;
                    if (do_write) begin
                        r_val[wr_addr] <= 1'b1;
                    end
                    if (do_mark) begin
                        r_skip[off_idx] <= 1'b1;
                    end
                    if (do_adv) begin
                        r_serv  <= r_serv + 1'b1;
                        r_skip  <= r_skip >> 1;
                        r_state <= trwl_pkg::S_ADV;
                    end else begin
                        o_done          <= 1'b1;
                        o_status        <= n_status;
                        o_issued_ticket <= n_issued;
                        o_all_free      <= (n_rcnt == '0) && (n_wcnt == '0);
                        r_state         <= trwl_pkg::S_IDLE;
                    end
                end
                trwl_pkg::S_ADV: begin
                    // pass over cancelled tickets
                    if (r_skip[0] && r_serv != r_next) begin
                        r_serv <= r_serv + 1'b1;
                        r_skip <= r_skip >> 1;
                    end else begin
                        if (r_serv == r_next) begin
                            r_skip <= '0;
                        end
                        o_done          <= 1'b1;
                        o_status        <= r_status;
                        o_issued_ticket <= r_issued;
                        o_all_free      <= (r_rcnt == '0) && (r_wcnt == '0);
                        r_state         <= trwl_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= trwl_pkg::S_IDLE;
                end
            endcase
        end
    end

    `TRWL_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, busy,
        "request accepted but not busy")
    `TRWL_ASSERT_SAME(a_rw_exclusive, i_clk, i_rst_n, 1'b1,
        (r_rcnt == '0) || (r_wcnt == '0), "readers and writer hold together")
    `TRWL_ASSERT_SAME(a_one_writer, i_clk, i_rst_n, 1'b1, r_wcnt <= CW'(1),
        "more than one writer holds")
    `TRWL_ASSERT_SAME(a_free_match, i_clk, i_rst_n, o_done,
        o_all_free == ((r_rcnt == '0) && (r_wcnt == '0)),
        "all_free disagrees with holder counts")
    `TRWL_ASSERT_SAME(a_head_unskipped, i_clk, i_rst_n, r_state == trwl_pkg::S_IDLE,
        !r_skip[0], "served ticket marked skipped")

endmodule
